// ----- rtl/tour_segment_permuter_defines.svh -----
// Assertion macros shared by the tour segment permuter RTL.
// Define NO_ASSERTIONS to compile the checks out; needs clk_i and rst_ni in scope.
`ifndef TOUR_SEGMENT_PERMUTER_DEFINES_SVH
`define TOUR_SEGMENT_PERMUTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property at every clock edge outside reset.
`define TSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tour segment permuter: assertion failed");

// Check a property at every clock edge, reset included.
`define TSP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tour segment permuter: assertion failed during or after reset");

`else

`define TSP_ASSERT(lbl, prop)
`define TSP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- rtl/tsp_pkg.sv -----
// Shared constants and types for the tour segment permuter.
// Used by tsp_ram and tour_segment_permuter; depends on nothing.
package tsp_pkg;

  localparam int MAX_CITIES = 256;
  localparam int CITY_BITS  = 16;

  // Fixed field widths of the stream items and the length register.
  localparam int POS_W      = 8;
  localparam int CITY_OUT_W = 16;
  localparam int CMD_W      = 3;
  localparam int CFG_W      = 9;

  localparam int ADDR_W = $clog2(MAX_CITIES);
  localparam int LEN_W  = ADDR_W + 1;
  localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_REVERSE = 3'd2,
    CMD_SLIDE   = 3'd3,
    CMD_ROTATE  = 3'd4,
    CMD_SWAP    = 3'd5
  } cmd_e;

endpackage

// ----- rtl/tsp_ram.sv -----
// Tour store: one write port and two registered read ports.
// Depends on tsp_pkg for depth and entry width.
module tsp_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [tsp_pkg::ADDR_W-1:0]    waddr_i,
  input  logic [tsp_pkg::CITY_BITS-1:0] wdata_i,
  input  logic [tsp_pkg::ADDR_W-1:0]    raddr_a_i,
  input  logic [tsp_pkg::ADDR_W-1:0]    raddr_b_i,
  output logic [tsp_pkg::CITY_BITS-1:0] rdata_a_o,
  output logic [tsp_pkg::CITY_BITS-1:0] rdata_b_o
);
  import tsp_pkg::*;

  logic [CITY_BITS-1:0] mem_q [MAX_CITIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- rtl/tour_segment_permuter.sv -----
// Top level of the tour segment permuter: command sequencer around the tour store.
// Depends on tsp_pkg, tsp_ram and tour_segment_permuter_defines.svh.
//
// Channel   Dir  Handshake                    Carries
// s_axis    in   s_axis_tvalid/s_axis_tready  command (tuser), positions and city id (tdata)
// m_axis    out  m_axis_tvalid/m_axis_tready  read city (tdata), status (tuser)
// cfg       in   cfg_we_i                     tour length
//
// Flow: a write or a rejected command goes straight to the result state, a read through
// ST_RDW, a swap through ST_RD, ST_WR_LO and ST_WR_HI. A reversal sets up its bounds in
// ST_LOAD and runs ST_RD, ST_WR_LO and ST_WR_HI per exchanged pair; a rotate or slide runs
// three reversals. The single write port of the store sets this: each pair needs two writes.
// Reset clears the sequencer, the length and the output valid flag; the store and result
// data hold no reset value. s_axis_tready is high only while idle, and a finished result
// waits in the sequencer until the output register is free, so m_axis stalls hold the block.
`include "tour_segment_permuter_defines.svh"

module tour_segment_permuter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: tour length
  input  logic                           cfg_we_i,
  input  logic [tsp_pkg::CFG_W-1:0]      cfg_wdata_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] pos_a, [15:8] pos_b, [23:16] pos_c, [39:24] city_value
  input  logic [39:0]                    s_axis_tdata,
  // [2:0] command
  input  logic [tsp_pkg::CMD_W-1:0]      s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] read_city
  output logic [tsp_pkg::CITY_OUT_W-1:0] m_axis_tdata,
  // [0] status
  output logic                           m_axis_tuser
);
  import tsp_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_WR_LO = 7'b0001000,
    ST_WR_HI = 7'b0010000,
    ST_RDW   = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_e;

  // Which of the three reversals of a rotation is running.
  typedef enum logic [1:0] {
    PH_LEFT  = 2'd0,
    PH_RIGHT = 2'd1,
    PH_WHOLE = 2'd2
  } phase_e;

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [CFG_W-1:0]     len_q;
  logic [ADDR_W-1:0]    x_q, x_d, y_q, y_d, z_q, z_d;
  logic [LEN_W-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic                 swap_q, swap_d;
  logic [CITY_OUT_W-1:0] res_city_q, res_city_d;
  logic                 res_err_q, res_err_d;
  logic                 m_valid_q;
  logic [CITY_OUT_W-1:0] m_city_q;
  logic                 m_err_q;

  // Store port signals.
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [CITY_BITS-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

  // Input decode.
  logic                 s_xfer;
  cmd_e                 cmd_in;
  logic [CMP_W-1:0]     pa, pb, pc, len_c;
  logic [LEN_W-1:0]     len_eff;
  logic                 cmd_ok;
  logic                 out_load;

  // Shared pointer unit: load, step and compare of the pair pointers.
  logic [LEN_W-1:0]     lo_ld, hi_ld, lo_inc, hi_dec;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign cmd_in = cmd_e'(s_axis_tuser);
  assign pa     = CMP_W'(s_axis_tdata[7:0]);
  assign pb     = CMP_W'(s_axis_tdata[15:8]);
  assign pc     = CMP_W'(s_axis_tdata[23:16]);

  // Clamp the programmed length to the store depth.
  always_comb begin
    if ((CFG_W + LEN_W)'(len_q) > (CFG_W + LEN_W)'(MAX_CITIES)) begin
      len_eff = LEN_W'(MAX_CITIES);
    end else begin
      len_eff = LEN_W'(len_q);
    end
  end
  assign len_c = CMP_W'(len_eff);

  // Preconditions of each command.
  always_comb begin
    case (cmd_in)
      CMD_WRITE:   cmd_ok = pa < len_c;
      CMD_READ:    cmd_ok = pa < len_c;
      CMD_REVERSE: cmd_ok = (pa < pb) && (pb < len_c);
      CMD_SLIDE:   cmd_ok = (pa < len_c) && (pb < len_c) && (pc < len_c) && (pb <= pc)
                            && ((pa < pb) || (pc <= pa));
      CMD_ROTATE:  cmd_ok = (pa < pb) && (pb < pc) && (pc < len_c);
      CMD_SWAP:    cmd_ok = (pa < pb) && (pb < len_c);
      default:     cmd_ok = 1'b0;
    endcase
  end

  // Bounds of the reversal for the current phase, inclusive.
  always_comb begin
    case (phase_q)
      PH_LEFT: begin
        lo_ld = LEN_W'(x_q) + LEN_W'(1);
        hi_ld = LEN_W'(y_q);
      end
      PH_RIGHT: begin
        lo_ld = LEN_W'(y_q) + LEN_W'(1);
        hi_ld = LEN_W'(z_q);
      end
      PH_WHOLE: begin
        lo_ld = LEN_W'(x_q) + LEN_W'(1);
        hi_ld = LEN_W'(z_q);
      end
      default: begin
        lo_ld = lo_q;
        hi_ld = hi_q;
      end
    endcase
  end

  assign lo_inc = lo_q + LEN_W'(1);
  assign hi_dec = hi_q - LEN_W'(1);

  assign out_load = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    x_d        = x_q;
    y_d        = y_q;
    z_d        = z_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    swap_d     = swap_q;
    res_city_d = res_city_q;
    res_err_d  = res_err_q;

    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          res_city_d = '0;
          res_err_d  = !cmd_ok;
          swap_d     = 1'b0;
          state_d    = ST_RESP;
          if (cmd_ok) begin
            case (cmd_in)
              CMD_READ: state_d = ST_RDW;
              CMD_REVERSE: begin
                x_d     = ADDR_W'(pa);
                z_d     = ADDR_W'(pb);
                phase_d = PH_WHOLE;
                state_d = ST_LOAD;
              end
              CMD_ROTATE, CMD_SLIDE: begin
                // Slide with place behind the segment turns the span first+1..place.
                if (pa < pb) begin
                  x_d = ADDR_W'(pa);
                  y_d = ADDR_W'(pb);
                  z_d = ADDR_W'(pc);
                end else begin
                  x_d = ADDR_W'(pb);
                  y_d = ADDR_W'(pc);
                  z_d = ADDR_W'(pa);
                end
                phase_d = PH_LEFT;
                state_d = ST_LOAD;
              end
              CMD_SWAP: begin
                lo_d    = LEN_W'(pa);
                hi_d    = LEN_W'(pb);
                swap_d  = 1'b1;
                state_d = ST_RD;
              end
              default: state_d = ST_RESP;
            endcase
          end
        end
      end
      ST_LOAD: begin
        lo_d = lo_ld;
        hi_d = hi_ld;
        if (lo_ld < hi_ld) begin
          state_d = ST_RD;
        end else if (phase_q == PH_WHOLE) begin
          state_d = ST_RESP;
        end else begin
          phase_d = phase_e'(phase_q + 2'd1);
        end
      end
      ST_RD:    state_d = ST_WR_LO;
      ST_WR_LO: state_d = ST_WR_HI;
      ST_WR_HI: begin
        lo_d = lo_inc;
        hi_d = hi_dec;
        if (swap_q) begin
          state_d = ST_RESP;
        end else if (lo_inc < hi_dec) begin
          state_d = ST_RD;
        end else if (phase_q == PH_WHOLE) begin
          state_d = ST_RESP;
        end else begin
          phase_d = phase_e'(phase_q + 2'd1);
          state_d = ST_LOAD;
        end
      end
      ST_RDW: begin
        res_city_d = CITY_OUT_W'(ram_rdata_a);
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Store accesses: a write command writes on its transfer; a pair exchange reads both
  // ends at once and writes them back one after the other.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo_q[ADDR_W-1:0];
    ram_wdata = ram_rdata_b;
    case (state_q)
      ST_IDLE: begin
        ram_we    = s_xfer && cmd_ok && (cmd_in == CMD_WRITE);
        ram_waddr = ADDR_W'(pa);
        ram_wdata = CITY_BITS'(s_axis_tdata[39:24]);
      end
      ST_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[ADDR_W-1:0];
        ram_wdata = ram_rdata_b;
      end
      ST_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q[ADDR_W-1:0];
        ram_wdata = ram_rdata_a;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign ram_raddr_a = (state_q == ST_IDLE) ? ADDR_W'(pa) : lo_q[ADDR_W-1:0];
  assign ram_raddr_b = hi_q[ADDR_W-1:0];

  tsp_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_LEFT;
      swap_q    <= 1'b0;
      len_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      swap_q  <= swap_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    z_q        <= z_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    res_city_q <= res_city_d;
    res_err_q  <= res_err_d;
    if (out_load) begin
      m_city_q <= res_city_q;
      m_err_q  <= res_err_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_city_q;
  assign m_axis_tuser  = m_err_q;

  // A rejected command must never touch the store.
  `TSP_ASSERT(a_no_write_on_reject, (s_xfer && !cmd_ok) |-> !ram_we)
  // A pair is only fetched with its ends strictly in order.
  `TSP_ASSERT(a_pair_in_order, (state_q == ST_RD) |-> (lo_q < hi_q))
  // After the second write of a pair the walk continues, reloads or finishes.
  `TSP_ASSERT(a_after_pair, (state_q == ST_WR_HI) |=>
    (state_q == ST_RD || state_q == ST_LOAD || state_q == ST_RESP))
  // A new result is loaded only from the result state.
  `TSP_ASSERT(a_load_from_resp, (m_axis_tvalid && !$past(m_axis_tvalid)) |->
    ($past(state_q) == ST_RESP))
  // No result is offered while in reset.
  `TSP_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !m_axis_tvalid)

endmodule
